/* src/nva_pkg.sv */
// Package: shared types for the note voice allocator.
package nva_pkg;

  // Note and velocity widths fixed by the MIDI event format, plus the voice index width
  localparam int unsigned NoteW  = 7;
  localparam int unsigned VelW   = 7;
  localparam int unsigned VoiceW = 3;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Result handed from the controller to the output register
  typedef struct packed {
    logic              vld;
    logic [VoiceW-1:0] voice;
    logic [VelW-1:0]   vel;
    logic [NoteW-1:0]  note;
    logic              sent;
  } res_t;

  // Controller status seen by the top level
  typedef struct packed {
    logic busy;
  } stat_t;

endpackage

/* src/nva_if.sv */
// Interfaces: note event input channel and voice update output channel.
interface nva_in_if;
  logic                      valid;
  logic                      ready;
  logic [nva_pkg::NoteW-1:0] note_number;
  logic [nva_pkg::VelW-1:0]  note_velocity;

  modport source (output valid, output note_number, output note_velocity, input ready);
  modport sink   (input valid, input note_number, input note_velocity, output ready);
endinterface

interface nva_out_if;
  logic                       valid;
  logic                       ready;
  logic [nva_pkg::VoiceW-1:0] voice_index;
  logic [nva_pkg::VelW-1:0]   out_velocity;
  logic [nva_pkg::NoteW-1:0]  out_note;
  logic                       note_sent;

  modport source (output valid, output voice_index, output out_velocity, output out_note,
                  output note_sent, input ready);
  modport sink   (input valid, input voice_index, input out_velocity, input out_note,
                  input note_sent, output ready);
endinterface

/* src/nva_ram.sv */
// Generic simple dual-port RAM with registered read.
module nva_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/nva_ctrl.sv */
// Controller: rotation pointer, sounding flags and note-off scan over the note RAM.
module nva_ctrl #(
  parameter int unsigned NUM_VOICES = 8,
  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1,
  localparam int unsigned LW = $clog2(NUM_VOICES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [nva_pkg::NoteW-1:0] in_note,
  input  logic [nva_pkg::VelW-1:0]  in_vel,
  input  logic                      out_free,
  output nva_pkg::res_t             res,
  output nva_pkg::stat_t            stat,
  // note RAM
  output logic                      ram_we,
  output logic [VW-1:0]             ram_waddr,
  output logic [nva_pkg::NoteW-1:0] ram_wdata,
  output logic                      ram_re,
  output logic [VW-1:0]             ram_raddr,
  input  logic [nva_pkg::NoteW-1:0] ram_rdata
);

  nva_pkg::state_t           state_r, state_nxt;
  logic [VW-1:0]             head_r, head_nxt;
  logic [NUM_VOICES-1:0]     sounding_r, sounding_nxt;
  logic [nva_pkg::NoteW-1:0] note_r, note_nxt;
  logic [VW-1:0]             issue_v_r, issue_v_nxt;
  logic [LW-1:0]             left_r, left_nxt;
  logic [VW-1:0]             chk_v_r, chk_v_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic                      in_fire;
  logic                      hit;

  function automatic logic [VW-1:0] next_voice(input logic [VW-1:0] v);
    return (v == VW'(NUM_VOICES - 1)) ? '0 : v + 1'b1;
  endfunction

  assign in_fire = in_valid && in_ready;

  // Compare the entry last read from the RAM against the note being released
  assign hit = chk_vld_r && sounding_r[chk_v_r] && (ram_rdata == note_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nva_pkg::ST_IDLE: begin
        if (in_fire && (in_vel == '0)) begin
          state_nxt = nva_pkg::ST_SCAN;
        end
      end
      nva_pkg::ST_SCAN: begin
        if (hit) begin
          if (out_free) begin
            state_nxt = nva_pkg::ST_IDLE;
          end
        end else if (left_r == '0) begin
          state_nxt = nva_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nva_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    in_ready     = 1'b0;
    res          = '0;
    ram_we       = 1'b0;
    ram_waddr    = head_r;
    ram_wdata    = in_note;
    ram_re       = 1'b0;
    ram_raddr    = issue_v_r;
    head_nxt     = head_r;
    sounding_nxt = sounding_r;
    note_nxt     = note_r;
    issue_v_nxt  = issue_v_r;
    left_nxt     = left_r;
    chk_v_nxt    = chk_v_r;
    chk_vld_nxt  = chk_vld_r;
    case (state_r)
      nva_pkg::ST_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          if (in_vel != '0) begin
            // note-on: take the voice under the pointer
            ram_we               = 1'b1;
            sounding_nxt[head_r] = 1'b1;
            head_nxt             = next_voice(head_r);
            res.vld              = 1'b1;
            res.voice            = nva_pkg::VoiceW'(head_r);
            res.vel              = in_vel;
            res.note             = in_note;
            res.sent             = 1'b1;
          end else begin
            // note-off: arm the scan from the pointer
            note_nxt    = in_note;
            issue_v_nxt = head_r;
            left_nxt    = LW'(NUM_VOICES);
            chk_vld_nxt = 1'b0;
          end
        end
      end
      nva_pkg::ST_SCAN: begin
        if (hit) begin
          // hold read data until the output slot frees
          if (out_free) begin
            sounding_nxt[chk_v_r] = 1'b0;
            res.vld               = 1'b1;
            res.voice             = nva_pkg::VoiceW'(chk_v_r);
          end
        end else if (left_r != '0) begin
          ram_re      = 1'b1;
          chk_v_nxt   = issue_v_r;
          chk_vld_nxt = 1'b1;
          issue_v_nxt = next_voice(issue_v_r);
          left_nxt    = left_r - 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign stat.busy = (state_r == nva_pkg::ST_SCAN);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nva_pkg::ST_IDLE;
      head_r     <= '0;
      sounding_r <= '0;
      chk_vld_r  <= 1'b0;
      left_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      sounding_r <= sounding_nxt;
      chk_vld_r  <= chk_vld_nxt;
      left_r     <= left_nxt;
    end
  end

  // Scan payload registers
  always_ff @(posedge clk) begin
    note_r    <= note_nxt;
    issue_v_r <= issue_v_nxt;
    chk_v_r   <= chk_v_nxt;
  end

endmodule

/* src/note_voice_allocator.sv */
// Top level: round-robin note voice allocator with output register.
// Each request is one note event. A note-on (nonzero velocity) is accepted
// and its voice update appears in the output register on the next cycle;
// it claims the voice under the rotation pointer, stealing it if it sounds. A
// note-off scans the per-voice note RAM from the pointer, one voice read per
// cycle through the RAM's single read port until a match is found, and holds
// off new requests until a match is found or every voice has been read, and
// while a match waits for a full output register to drain; a note-off that
// matches no sounding voice gives no result. A new request is taken once the
// block is idle and the output register is empty or being drained. The
// sounding flags are cleared by reset at once, so no clearing pass is needed.
module note_voice_allocator #(
  parameter int unsigned NUM_VOICES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  nva_in_if.sink       in_ch,
  nva_out_if.source    out_ch
);

  localparam int unsigned VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  nva_pkg::res_t             res;
  nva_pkg::stat_t            stat;
  logic                      out_free;
  logic                      ram_we;
  logic [VW-1:0]             ram_waddr;
  logic [nva_pkg::NoteW-1:0] ram_wdata;
  logic                      ram_re;
  logic [VW-1:0]             ram_raddr;
  logic [nva_pkg::NoteW-1:0] ram_rdata;

  logic                       out_valid_r;
  logic [nva_pkg::VoiceW-1:0] voice_r;
  logic [nva_pkg::VelW-1:0]   vel_r;
  logic [nva_pkg::NoteW-1:0]  note_r;
  logic                       sent_r;

  assign out_free = !out_valid_r || out_ch.ready;

  // Per-voice note store
  nva_ram #(
    .WIDTH (nva_pkg::NoteW),
    .DEPTH (NUM_VOICES)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nva_ctrl #(
    .NUM_VOICES (NUM_VOICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_note   (in_ch.note_number),
    .in_vel    (in_ch.note_velocity),
    .out_free  (out_free),
    .res       (res),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.vld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (res.vld) begin
      voice_r <= res.voice;
      vel_r   <= res.vel;
      note_r  <= res.note;
      sent_r  <= res.sent;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.voice_index  = voice_r;
  assign out_ch.out_velocity = vel_r;
  assign out_ch.out_note     = note_r;
  assign out_ch.note_sent    = sent_r;

  // A note-on shows up in the output register on the next cycle
  a_note_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.note_velocity != '0)) |=>
      (out_ch.valid && out_ch.note_sent &&
       (out_ch.out_velocity == $past(in_ch.note_velocity))))
    else $error("note-on result missing");

  // No request is taken while a note-off scan runs
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ch.ready)
    else $error("request accepted during scan");

  // A note-off update carries no note and zero velocity
  a_note_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.note_sent) |->
      ((out_ch.out_velocity == '0) && (out_ch.out_note == '0)))
    else $error("note-off result carries note data");

endmodule

/* tb/note_voice_allocator_tb.sv */
// Testbench for the note voice allocator: directed and random note events against a voice model.
module note_voice_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_VOICES = 8;
  localparam int unsigned CLK_HALF   = 4;
  localparam int unsigned RESET_CYCLES = 11;
  // Wait allowance for a note-off scan over every voice
  localparam int unsigned SCAN_CYCLES = NUM_VOICES + 2;
  localparam int unsigned DRAIN_LIMIT = 200000;
  localparam logic [nva_pkg::VelW-1:0] VEL_NOTE_OFF = '0;
  localparam logic [nva_pkg::VelW-1:0] VEL_MAX = '1;
  localparam logic [nva_pkg::NoteW-1:0] NOTE_MAX = '1;
  localparam logic SENT_NOTE_ON  = 1'b1;
  localparam logic SENT_NOTE_OFF = 1'b0;

  // One voice update as the block reports it
  typedef struct packed {
    logic [nva_pkg::VoiceW-1:0] voice;
    logic [nva_pkg::VelW-1:0]   vel;
    logic [nva_pkg::NoteW-1:0]  note;
    logic                       sent;
  } voice_update_t;

  logic clk;
  logic rst_n;

  nva_in_if  in_ch ();
  nva_out_if out_ch ();

  note_voice_allocator #(
    .NUM_VOICES(NUM_VOICES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Voice model state
  logic [nva_pkg::NoteW-1:0] held_note [NUM_VOICES];
  logic                      voice_on  [NUM_VOICES];
  int unsigned               rotation_ptr;

  voice_update_t pending_updates[$];
  int unsigned   update_count;
  int unsigned   failures;
  int unsigned   in_idle_pct;
  int unsigned   out_idle_pct;

  // Clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // Model one accepted note event and queue the update it causes
  task automatic allocate_voice(input logic [nva_pkg::NoteW-1:0] note,
                                input logic [nva_pkg::VelW-1:0] vel);
    int unsigned v;
    voice_update_t upd;
    if (vel != VEL_NOTE_OFF) begin
      v = rotation_ptr;
      held_note[v] = note;
      voice_on[v] = 1'b1;
      rotation_ptr = (v + 1 >= NUM_VOICES) ? 0 : v + 1;
      upd.voice = v[nva_pkg::VoiceW-1:0];
      upd.vel   = vel;
      upd.note  = note;
      upd.sent  = SENT_NOTE_ON;
      pending_updates = {pending_updates, upd};
      update_count++;
    end else begin
      // Search from the pointer for the first sounding voice on this note
      v = rotation_ptr;
      for (int n = 0; n < NUM_VOICES; n++) begin
        if (voice_on[v] && held_note[v] == note) begin
          voice_on[v] = 1'b0;
          upd.voice = v[nva_pkg::VoiceW-1:0];
          upd.vel   = VEL_NOTE_OFF;
          upd.note  = '0;
          upd.sent  = SENT_NOTE_OFF;
          pending_updates = {pending_updates, upd};
          update_count++;
          break;
        end
        v = (v + 1 >= NUM_VOICES) ? 0 : v + 1;
      end
    end
  endtask

  // Pick a note held by some sounding voice, if any
  task automatic pick_held_note(output bit found, output logic [nva_pkg::NoteW-1:0] note);
    int unsigned cnt;
    int unsigned pick;
    cnt = 0;
    found = 1'b0;
    note = '0;
    for (int i = 0; i < NUM_VOICES; i++) if (voice_on[i]) cnt++;
    if (cnt != 0) begin
      pick = $urandom_range(cnt - 1);
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (voice_on[i]) begin
          if (pick == 0 && !found) begin
            note = held_note[i];
            found = 1'b1;
          end
          if (pick != 0) pick--;
        end
      end
    end
  endtask

  // Send one note event request, with random idle cycles in front
  task automatic send_event(input logic [nva_pkg::NoteW-1:0] note,
                            input logic [nva_pkg::VelW-1:0] vel);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.note_number   <= note;
    in_ch.note_velocity <= vel;
    do @(posedge clk); while (!in_ch.ready);
    allocate_voice(note, vel);
  endtask

  // Stop sending until every queued update has come out or the drain limit runs out
  task automatic wait_updates_drained();
    int unsigned cycles;
    cycles = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
  endtask

  // Extremes, note-off hit and miss, stealing and duplicate notes
  task automatic test_directed_events();
    send_event('0, VEL_MAX);
    send_event(NOTE_MAX, 7'd1);
    send_event('0, VEL_NOTE_OFF);
    send_event('0, VEL_NOTE_OFF);        // no voice holds it any more
    send_event(NOTE_MAX, VEL_NOTE_OFF);
    // Fill every voice, then one more steals the oldest
    for (int i = 0; i < NUM_VOICES; i++) send_event(7'(60 + i), 7'(10 + i * 14));
    send_event(7'd70, 7'd99);
    send_event(7'd60, VEL_NOTE_OFF);     // stolen note: no update
    send_event(7'd70, VEL_NOTE_OFF);
    // Same note on two voices: the first one from the pointer is released
    send_event(7'd72, 7'd42);
    send_event(7'd72, 7'd85);
    send_event(7'd72, VEL_NOTE_OFF);
    send_event(7'd72, VEL_NOTE_OFF);
    send_event(7'd61, VEL_NOTE_OFF);
    send_event(7'd67, VEL_NOTE_OFF);
  endtask

  // Random phrases: mostly note-ons and releases of held notes, some stray note-offs
  task automatic test_random_phrases(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned n_updates);
    int unsigned start;
    int unsigned r;
    bit found;
    logic [nva_pkg::NoteW-1:0] note;
    logic [nva_pkg::VelW-1:0] vel;
    in_idle_pct  = src_pct;
    out_idle_pct = snk_pct;
    start = update_count;
    while (update_count - start < n_updates) begin
      r = $urandom_range(99);
      if (r < 55) begin
        note = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'(48 + $urandom_range(23));
        case ($urandom_range(9))
          0:       vel = VEL_MAX;
          1:       vel = 7'd1;
          default: vel = 7'($urandom_range(127, 1));
        endcase
        send_event(note, vel);
      end else if (r < 90) begin
        pick_held_note(found, note);
        if (!found) note = 7'($urandom_range(127));
        send_event(note, VEL_NOTE_OFF);
      end else begin
        send_event(7'($urandom_range(127)), VEL_NOTE_OFF);
      end
    end
  endtask

  // Burst of requests against a slow receiver, hold off until all is out, then random note-offs
  task automatic test_backlog_pause();
    in_idle_pct  = 0;
    out_idle_pct = 90;
    for (int i = 0; i < 16; i++) send_event(7'($urandom_range(127)), 7'($urandom_range(127, 1)));
    wait_updates_drained();
    for (int i = 0; i < 8; i++) send_event(7'($urandom_range(127)), VEL_NOTE_OFF);
  endtask

  // Receiver: check each accepted update, then pick ready for the next cycle
  always @(posedge clk) begin : check_updates
    voice_update_t oldest;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected update: voice %0d vel %0d note %0d sent %0d", out_ch.voice_index,
               out_ch.out_velocity, out_ch.out_note, out_ch.note_sent);
        failures++;
      end else begin
        oldest = pending_updates[0];
        pending_updates.delete(0);
        if (out_ch.voice_index !== oldest.voice) begin
          $error("voice_index: expected %0d, got %0d", oldest.voice, out_ch.voice_index);
          failures++;
        end
        if (out_ch.out_velocity !== oldest.vel) begin
          $error("out_velocity: expected %0d, got %0d", oldest.vel, out_ch.out_velocity);
          failures++;
        end
        if (out_ch.out_note !== oldest.note) begin
          $error("out_note: expected %0d, got %0d", oldest.note, out_ch.out_note);
          failures++;
        end
        if (out_ch.note_sent !== oldest.sent) begin
          $error("note_sent: expected %0d, got %0d", oldest.sent, out_ch.note_sent);
          failures++;
        end
      end
    end
    if (!rst_n) out_ch.ready <= 1'b0;
    else        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Main sequence
  initial begin
    failures = 0;
    update_count = 0;
    rotation_ptr = 0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      held_note[i] = '0;
      voice_on[i]  = 1'b0;
    end
    in_idle_pct  = 25;
    out_idle_pct = 74;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.note_number   <= '0;
    in_ch.note_velocity <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_random_phrases(25, 74, 560);
    test_backlog_pause();
    test_random_phrases(74, 25, 560);
    test_random_phrases(0, 0, 560);

    // Let the last scan finish and every update drain
    wait_updates_drained();
    repeat (SCAN_CYCLES + 4) @(posedge clk);
    if (pending_updates.size() != 0) begin
      $error("%0d expected updates never arrived", pending_updates.size());
      failures++;
    end
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/nva_pkg.sv
src/nva_if.sv
src/nva_ram.sv
src/nva_ctrl.sv
src/note_voice_allocator.sv
tb/note_voice_allocator_tb.sv
